FILE: design/assert_macros.svh
// shared assertion wrappers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define MRR_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// clocked check that also holds through reset
`define MRR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: design/mrr_pkg.sv
package mrr_pkg;

    localparam logic [30:0] SEED_RESET  = 31'd123456789;
    localparam logic [14:0] LCG_MULT    = 15'd16807;
    localparam logic [30:0] LCG_MOD     = 31'h7FFF_FFFF;
    localparam int          QUEUE_DEPTH = 2;

    // register byte-address select bit and index of the seed register
    localparam logic        REG_INITIAL_SEED = 1'b0;

    typedef struct packed {
        logic               int_mode;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [33:0] span;
    } mrr_job_t;

    typedef struct packed {
        logic        load;
        logic [30:0] seed;
    } mrr_seed_load_t;

endpackage

FILE: design/mrr_front.sv
module mrr_front (
    input  logic               action,
    input  logic signed [31:0] low_bound,
    input  logic signed [31:0] high_bound,
    output mrr_pkg::mrr_job_t  job
);

    logic swap;

    // integer mode orders the bounds, real mode keeps the direction
    assign swap = action && (high_bound < low_bound);

    always_comb begin
        job.int_mode = action;
        job.lo       = swap ? high_bound : low_bound;
        job.hi       = swap ? low_bound  : high_bound;
        job.span     = 34'(job.hi) - 34'(job.lo) + (action ? 34'sd1 : 34'sd0);
    end

endmodule

FILE: design/mrr_queue.sv
`include "assert_macros.svh"

module mrr_queue #(
    parameter int DEPTH = mrr_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mrr_pkg::mrr_job_t push_data,
    output logic              full,
    output logic              valid,
    input  logic              pop,
    output mrr_pkg::mrr_job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mrr_pkg::mrr_job_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `MRR_ASSERT(a_no_push_full, aclk, aresetn, push |-> !full)
    `MRR_ASSERT(a_no_pop_empty, aclk, aresetn, pop |-> valid)

endmodule

FILE: design/mrr_back.sv
`include "assert_macros.svh"

module mrr_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mrr_pkg::mrr_seed_load_t seed_load,
    input  logic                   q_valid,
    input  mrr_pkg::mrr_job_t      q_data,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [63:0]            m_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FOLD  = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [30:0]        seed_reg, seed_next;
    mrr_pkg::mrr_job_t  job_reg;
    logic [45:0]        prod_reg;
    logic signed [50:0] pp_lo_reg;
    logic signed [49:0] pp_hi_reg;
    logic signed [34:0] offset_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic signed [31:0] value_reg;
    logic [30:0]        raw_seed_reg;

    logic [31:0]        fold;
    logic signed [65:0] sum_full;
    logic signed [35:0] v_sum;
    logic signed [31:0] v_final;
    logic               out_free;

    // mersenne fold: high part plus low part, one subtract brings it below the modulus
    assign fold     = 32'(prod_reg[45:31]) + 32'(prod_reg[30:0]);
    assign sum_full = (66'(pp_hi_reg) <<< 16) + 66'(pp_lo_reg);
    assign v_sum    = 36'(job_reg.lo) + 36'(offset_reg);
    assign v_final  = (job_reg.int_mode && (v_sum > 36'(job_reg.hi))) ? job_reg.hi
                                                                      : 32'(v_sum);
    assign out_free = !m_tvalid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        state_next    = state_reg;
        seed_next     = seed_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                seed_next  = (fold >= 32'(mrr_pkg::LCG_MOD)) ?
                             31'(fold - 32'(mrr_pkg::LCG_MOD)) : 31'(fold);
                state_next = ST_SCALE;
            end
            ST_SCALE: state_next = ST_SUM;
            ST_SUM:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (seed_load.load) seed_next = seed_load.seed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seed_reg     <= mrr_pkg::SEED_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seed_reg     <= seed_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg  <= q_data;
            prod_reg <= 46'(seed_reg) * 46'(mrr_pkg::LCG_MULT);
        end
        if (state_reg == ST_SCALE) begin
            // span times new seed, split over the seed halves
            pp_lo_reg <= 51'(job_reg.span) * 51'($signed({1'b0, seed_reg[15:0]}));
            pp_hi_reg <= 50'(job_reg.span) * 50'($signed({1'b0, seed_reg[30:16]}));
        end
        if (state_reg == ST_SUM) begin
            offset_reg <= 35'(sum_full >>> 31);
        end
        if ((state_reg == ST_OUT) && out_free) begin
            value_reg    <= v_final;
            raw_seed_reg <= seed_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, raw_seed_reg, value_reg};

    `MRR_ASSERT(a_seed_reduced, aclk, aresetn,
        (state_reg == ST_FOLD) && !seed_load.load |=> seed_reg != mrr_pkg::LCG_MOD)
    `MRR_ASSERT(a_hold_on_stall, aclk, aresetn,
        (state_reg == ST_OUT) && m_tvalid_reg && !m_tready |=> state_reg == ST_OUT)

endmodule

FILE: design/minimal_standard_random_in_range.sv
// minimal standard random source with range scaling
//
// input channel s_*: one request word per handshake; s_tuser carries the mode
// (0 real fixed point, 1 integer), s_tdata the two bounds. result channel m_*:
// one word per request with the scaled value and the new generator state.
// apb port: register 0 (byte address 0) is initial_seed; writing it loads the
// generator state. write it only while no request is in flight.
// real mode returns low + floor((high - low) * seed / 2^31); bounds and value
// share one signed fixed-point format, whose fraction width does not enter the
// arithmetic. integer mode orders the bounds and returns low + floor(u * span).
// the back-end sequencer takes one request at a time through seed multiply,
// fold, split scaling multiply, sum and output load, and starts the next only
// once the word is loaded. a two-entry queue lets requests arrive while
// the back end works or the output word waits.
// reset: the generator state and initial_seed return to 123456789, queue and
// output empty. when m_tready is low the output word holds, the back end waits
// with its next result and s_tready drops once the queue fills.
module minimal_standard_random_in_range #(
    parameter int QUEUE_DEPTH = mrr_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // low_bound[31:0], high_bound[63:32]
    input  logic [0:0]  s_tuser,   // action[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // value[31:0], raw_seed[62:32], zero[63]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [30:0]             initial_seed_reg;
    logic                    cfg_write;
    mrr_pkg::mrr_seed_load_t seed_load;
    mrr_pkg::mrr_job_t       front_job;
    mrr_pkg::mrr_job_t       q_data;
    logic                    q_full;
    logic                    q_valid;
    logic                    q_pop;
    logic                    push;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == mrr_pkg::REG_INITIAL_SEED);
    assign prdata    = (paddr[2] == mrr_pkg::REG_INITIAL_SEED) ? {1'b0, initial_seed_reg}
                                                               : 32'd0;

    always_comb begin
        seed_load.load = cfg_write;
        seed_load.seed = pwdata[30:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_seed_reg <= mrr_pkg::SEED_RESET;
        end else if (cfg_write) begin
            initial_seed_reg <= pwdata[30:0];
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    mrr_front u_front (
        .action     (s_tuser[0]),
        .low_bound  ($signed(s_tdata[31:0])),
        .high_bound ($signed(s_tdata[63:32])),
        .job        (front_job)
    );

    mrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (front_job),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .pop_data  (q_data)
    );

    mrr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .seed_load (seed_load),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: dv/minimal_standard_random_in_range_test.sv
`timescale 1ns / 100ps

module minimal_standard_random_in_range_test;

    typedef enum logic {
        ACT_REAL = 1'b0,
        ACT_INT  = 1'b1
    } action_e;

    localparam logic [2:0] ADDR_INITIAL_SEED = 3'd0;
    localparam logic [2:0] ADDR_SPARE        = 3'd4;

    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic [30:0] SEED_TOP       = 31'd2147483646;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_WORDS     = 225;
    localparam int NUM_PHASES      = 6;
    localparam int NUM_ROWS        = 20;

    typedef struct packed {
        logic signed [31:0] value;
        logic [30:0]        raw_seed;
    } draw_t;

    typedef struct packed {
        action_e            act;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic               known;
        logic signed [31:0] value;
    } request_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // low_bound[31:0], high_bound[63:32]
    logic [0:0]  s_tuser;   // action[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // value[31:0], raw_seed[62:32], zero[63]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [30:0] seed_reg;
    logic [30:0] gen_seed;
    draw_t       expected_draws[$];
    int          fail_count   = 0;
    int          stall_cycles = 0;
    bit          hold_off_req = 1'b0;

    // fixed-point rows use 24 fraction bits, so 32'sh0100_0000 is 1.0
    request_row_t directed_rows [NUM_ROWS] = '{
        '{ACT_REAL, 32'sd0, 32'sd0, 1'b1, 32'sd0},
        '{ACT_INT, 32'sd0, 32'sd0, 1'b1, 32'sd0},
        '{ACT_REAL, S32_MAX, S32_MAX, 1'b1, S32_MAX},
        '{ACT_INT, S32_MAX, S32_MAX, 1'b1, S32_MAX},
        '{ACT_REAL, S32_MIN, S32_MIN, 1'b1, S32_MIN},
        '{ACT_INT, S32_MIN, S32_MIN, 1'b1, S32_MIN},
        '{ACT_REAL, S32_MIN, S32_MAX, 1'b0, 32'sd0},
        '{ACT_REAL, S32_MAX, S32_MIN, 1'b0, 32'sd0},
        '{ACT_INT, S32_MIN, S32_MAX, 1'b0, 32'sd0},
        '{ACT_INT, S32_MAX, S32_MIN, 1'b0, 32'sd0},
        '{ACT_INT, 32'sd10, -32'sd10, 1'b0, 32'sd0},
        '{ACT_REAL, 32'sh0100_0000, 32'sh0200_0000, 1'b0, 32'sd0},
        '{ACT_REAL, -32'sh0300_0000, 32'sh0500_0000, 1'b0, 32'sd0},
        '{ACT_INT, 32'sd1, 32'sd6, 1'b0, 32'sd0},
        '{ACT_INT, -32'sd1, 32'sd0, 1'b0, 32'sd0},
        '{ACT_REAL, 32'sd5, -32'sd5, 1'b0, 32'sd0},
        '{ACT_INT, 32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 32'sd0},
        '{ACT_REAL, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, 32'sd0},
        '{ACT_REAL, -32'sd1, 32'sd0, 1'b0, 32'sd0},
        '{ACT_INT, 32'sd0, -32'sd1, 1'b0, 32'sd0}
    };

    minimal_standard_random_in_range u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // advances the generator and scales the new seed into the range
    function automatic draw_t next_draw(action_e act, logic signed [31:0] lo_b,
                                        logic signed [31:0] hi_b);
        longint lo;
        longint hi;
        longint span;
        longint v;
        draw_t  d;
        gen_seed = 31'((longint'(gen_seed) * longint'(mrr_pkg::LCG_MULT))
                       % longint'(mrr_pkg::LCG_MOD));
        lo = lo_b;
        hi = hi_b;
        if (act == ACT_REAL) begin
            // arithmetic shift gives the floor for negative spans too
            v = lo + (((hi - lo) * longint'(gen_seed)) >>> 31);
        end else begin
            if (hi < lo) begin
                span = lo;
                lo   = hi;
                hi   = span;
            end
            span = hi - lo + 1;
            v = lo + ((span * longint'(gen_seed)) >>> 31);
            if (v < lo) v = lo;
            if (v > hi) v = hi;
        end
        d.value    = v[31:0];
        d.raw_seed = gen_seed;
        return d;
    endfunction

    task automatic send_request(action_e act, logic signed [31:0] lo, logic signed [31:0] hi,
                                logic known, logic signed [31:0] known_value);
        draw_t d;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {hi, lo};
        do @(posedge aclk); while (!s_tready);
        d = next_draw(act, lo, hi);
        if (known) d.value = known_value;
        expected_draws.push_back(d);
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return S32_MIN;
            1: return S32_MAX;
            2: return -32'sd1;
            3: return 32'sd0;
            default: return 32'sd1;
        endcase
    endfunction

    task automatic send_random_request();
        action_e            act;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        act = action_e'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0, 1: begin
                lo = $urandom;
                hi = $urandom;
            end
            2: begin
                lo = $urandom;
                hi = lo + $urandom_range(0, 64);
            end
            3: begin
                lo = $urandom;
                hi = lo;
            end
            4: begin
                lo = pick_extreme();
                hi = pick_extreme();
            end
            5: begin
                // fixed point within +-8.0
                lo = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
                hi = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
            end
            6: begin
                lo = $urandom_range(0, 200) - 100;
                hi = $urandom_range(0, 200) - 100;
            end
            default: begin
                hi = $urandom;
                lo = hi + $urandom_range(1, 1000);
            end
        endcase
        send_request(act, lo, hi, 1'b0, 32'sd0);
    endtask

    task automatic send_random_words(int count);
        int burst;
        int gap;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > count) burst = count;
            repeat (burst) send_random_request();
            count -= burst;
            gap = $urandom_range(0, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic apb_access(logic [2:0] addr, logic wr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (wr && addr == ADDR_INITIAL_SEED) begin
            seed_reg = wdata[30:0];
            gen_seed = seed_reg;
        end
    endtask

    task automatic check_seed_reg();
        logic [31:0] rd;
        apb_access(ADDR_INITIAL_SEED, 1'b0, 32'd0, rd);
        if (rd !== {1'b0, seed_reg}) begin
            $error("initial_seed readback: expected %0d, actual %0d", seed_reg, rd);
            fail_count++;
        end
    endtask

    // block is idle once every word is back and the pipeline has had time to empty
    task automatic wait_idle();
        while (expected_draws.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        draw_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_draws.size() == 0) begin
                $error("unexpected result word: value %0d, raw_seed %0d",
                       $signed(m_tdata[31:0]), m_tdata[62:32]);
                fail_count++;
            end else begin
                want = expected_draws.pop_front();
                if ($signed(m_tdata[31:0]) !== want.value) begin
                    $error("value: expected %0d, actual %0d", want.value,
                           $signed(m_tdata[31:0]));
                    fail_count++;
                end
                if (m_tdata[62:32] !== want.raw_seed) begin
                    $error("raw_seed: expected %0d, actual %0d", want.raw_seed,
                           m_tdata[62:32]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[minimal_standard_random_in_range] ERROR");
            $finish;
        end
    end

    // receiver: random ready runs and stalls, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
                if ($urandom_range(0, 3) != 0) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic [30:0] next_seed;
        logic [31:0] rd;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        seed_reg = mrr_pkg::SEED_RESET;
        gen_seed = mrr_pkg::SEED_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_seed_reg();
        foreach (directed_rows[i])
            send_request(directed_rows[i].act, directed_rows[i].lo, directed_rows[i].hi,
                         directed_rows[i].known, directed_rows[i].value);
        s_tvalid <= 1'b0;

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: next_seed = 31'd1;
                1: next_seed = SEED_TOP;
                3: next_seed = 31'd16807;
                default: next_seed = $urandom_range(1, SEED_TOP);
            endcase
            apb_access(ADDR_INITIAL_SEED, 1'b1, {1'b0, next_seed}, rd);
            // a write past the only register must leave the generator alone
            if (p == 2) apb_access(ADDR_SPARE, 1'b1, $urandom, rd);
            check_seed_reg();
            if (p == 3) hold_off_req = 1'b1;
            send_random_words(PHASE_WORDS);
            s_tvalid <= 1'b0;
        end

        wait_idle();
        if (fail_count == 0)
            $display("[minimal_standard_random_in_range] OK");
        else
            $display("[minimal_standard_random_in_range] ERROR");
        $finish;
    end

endmodule
